>>> rtl/ltc_pkg.sv
// Shared types, character codes and decode functions for the literal token classifier.
`default_nettype none

package ltc_pkg;

    localparam int VALUE_W  = 64;
    localparam int LENGTH_W = 16;

    typedef enum logic [1:0] {
        KIND_NUMBER   = 2'd0,
        KIND_BUFFER   = 2'd1,
        KIND_STRING   = 2'd2,
        KIND_OVERFLOW = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                 kind;
        logic [VALUE_W-1:0]    value;
        logic [LENGTH_W-1:0]   length;
    } result_t;

    // Class flag bit positions
    localparam int FLAG_HEX = 0;
    localparam int FLAG_BIN = 1;
    localparam int FLAG_DEC = 2;
    localparam int FLAG_BUF = 3;
    localparam int FLAG_W   = 4;

    // Character codes
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UB     = 8'h42;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_UX     = 8'h58;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LB     = 8'h62;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_LN     = 8'h6E;
    localparam logic [7:0] CH_LR     = 8'h72;
    localparam logic [7:0] CH_LT     = 8'h74;
    localparam logic [7:0] CH_LX     = 8'h78;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // {valid, digit value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            r = {1'b1, c[3:0]};
        end else if (c >= CH_LA && c <= CH_LF) begin
            r = {1'b1, 4'(c - CH_LA + 8'd10)};
        end else if (c >= CH_UA && c <= CH_UF) begin
            r = {1'b1, 4'(c - CH_UA + 8'd10)};
        end
        return r;
    endfunction

    // {valid, byte value}; the double quote counts only when dq_ok
    function automatic logic [8:0] esc_code(input logic [7:0] c, input logic dq_ok);
        logic [8:0] r;
        case (c)
            CH_LN:     r = {1'b1, 8'd10};
            CH_LT:     r = {1'b1, 8'd9};
            CH_LR:     r = {1'b1, 8'd13};
            CH_LB:     r = {1'b1, 8'd8};
            CH_ZERO:   r = {1'b1, 8'd0};
            CH_BSLASH: r = {1'b1, CH_BSLASH};
            CH_QUOTE:  r = {1'b1, CH_QUOTE};
            CH_DQUOTE: r = {dq_ok, CH_DQUOTE};
            default:   r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/ltc_core.sv
// Per-character classification state and result decode for one token.
`default_nettype none

module ltc_core #(
    parameter int LEN_BITS = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        s_ch,
    input  wire logic              s_last,
    input  wire logic              res_ready,
    output logic                   res_valid,
    output ltc_pkg::result_t       res_data
);

    localparam int CNT_W = (LEN_BITS < ltc_pkg::LENGTH_W) ? LEN_BITS : ltc_pkg::LENGTH_W;
    localparam logic [2:0] POS_MAX  = 3'd4;
    localparam logic [2:0] POS_HEAD = 3'd3;

    logic [63:0]                  accum_reg, accum_next;
    logic                         ovf_reg, ovf_next;
    logic [2:0]                   pos_reg;
    logic [7:0]                   head_reg [3];
    logic [ltc_pkg::FLAG_W-1:0]   flags_reg, flags_next;
    logic                         esc_reg, esc_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;

    logic        accept;
    logic        pos_is0, pos_is1, pos_ge2;
    logic        digit;
    logic [4:0]  hex_d;
    logic [8:0]  dq_esc;
    logic [8:0]  head_esc;
    logic [67:0] hex_sum;
    logic [64:0] bin_sum;
    logic [67:0] dec_sum;
    logic [7:0]  h0, h1, h2;
    logic        inc;
    logic        num_ok, char_ok;

    assign s_ready   = res_ready;
    assign accept    = s_valid & s_ready;
    assign res_valid = accept & s_last;

    assign pos_is0 = (pos_reg == 3'd0);
    assign pos_is1 = (pos_reg == 3'd1);
    assign pos_ge2 = ~pos_is0 & ~pos_is1;

    assign digit  = (s_ch >= ltc_pkg::CH_ZERO) && (s_ch <= ltc_pkg::CH_NINE);
    assign hex_d  = ltc_pkg::hex_digit(s_ch);
    assign dq_esc = ltc_pkg::esc_code(s_ch, 1'b1);

    // Head characters with the current beat merged in
    assign h0 = pos_is0             ? s_ch : head_reg[0];
    assign h1 = pos_is1             ? s_ch : head_reg[1];
    assign h2 = (pos_reg == 3'd2)   ? s_ch : head_reg[2];
    assign head_esc = ltc_pkg::esc_code(h2, 1'b0);

    // Multiply-add per base, with carry-out bits for overflow
    assign hex_sum = {accum_reg, 4'b0000} + 68'(hex_d[3:0]);
    assign bin_sum = {accum_reg, 1'b0} + 65'(s_ch[0]);
    assign dec_sum = {1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0}
                   + 68'(s_ch[3:0]);

    always_comb begin
        flags_next = flags_reg;
        accum_next = accum_reg;
        ovf_next   = ovf_reg;
        esc_next   = esc_reg;
        cnt_next   = cnt_reg;
        inc        = 1'b0;

        // numeric classes
        if (!digit) flags_next[ltc_pkg::FLAG_DEC] = 1'b0;
        if (pos_is0) begin
            if (s_ch != ltc_pkg::CH_ZERO) begin
                flags_next[ltc_pkg::FLAG_HEX] = 1'b0;
                flags_next[ltc_pkg::FLAG_BIN] = 1'b0;
            end
        end else if (pos_is1) begin
            if (s_ch != ltc_pkg::CH_LX && s_ch != ltc_pkg::CH_UX)
                flags_next[ltc_pkg::FLAG_HEX] = 1'b0;
            if (s_ch != ltc_pkg::CH_LB && s_ch != ltc_pkg::CH_UB)
                flags_next[ltc_pkg::FLAG_BIN] = 1'b0;
        end else begin
            if (!hex_d[4]) flags_next[ltc_pkg::FLAG_HEX] = 1'b0;
            if (s_ch != ltc_pkg::CH_ZERO && s_ch != ltc_pkg::CH_ONE)
                flags_next[ltc_pkg::FLAG_BIN] = 1'b0;
        end

        if (pos_ge2 && flags_next[ltc_pkg::FLAG_HEX]) begin
            accum_next = hex_sum[63:0];
            if (|hex_sum[67:64]) ovf_next = 1'b1;
        end else if (pos_ge2 && flags_next[ltc_pkg::FLAG_BIN]) begin
            accum_next = bin_sum[63:0];
            if (bin_sum[64]) ovf_next = 1'b1;
        end else if (flags_next[ltc_pkg::FLAG_DEC]) begin
            accum_next = dec_sum[63:0];
            if (|dec_sum[67:64]) ovf_next = 1'b1;
        end

        // buffer class
        if (pos_is0) begin
            if (s_ch != ltc_pkg::CH_DQUOTE) flags_next[ltc_pkg::FLAG_BUF] = 1'b0;
        end else if (!s_last && flags_next[ltc_pkg::FLAG_BUF]) begin
            if (esc_reg) begin
                if (!dq_esc[8]) flags_next[ltc_pkg::FLAG_BUF] = 1'b0;
                else            inc = 1'b1;
                esc_next = 1'b0;
            end else if (s_ch == ltc_pkg::CH_BSLASH) begin
                esc_next = 1'b1;
            end else begin
                inc = 1'b1;
            end
            if (inc && cnt_reg != '1) cnt_next = cnt_reg + 1'b1;
        end
        if (s_last && (!pos_ge2 || s_ch != ltc_pkg::CH_DQUOTE || esc_reg))
            flags_next[ltc_pkg::FLAG_BUF] = 1'b0;

        // result decode on the final beat
        num_ok = ((flags_next[ltc_pkg::FLAG_HEX] | flags_next[ltc_pkg::FLAG_BIN]) && !pos_is0)
               || flags_next[ltc_pkg::FLAG_DEC];
        char_ok = pos_ge2 && h0 == ltc_pkg::CH_QUOTE && s_ch == ltc_pkg::CH_QUOTE
                && ((h1 == ltc_pkg::CH_BSLASH) ? head_esc[8] : (pos_reg == 3'd2));

        res_data.kind   = ltc_pkg::KIND_STRING;
        res_data.value  = '0;
        res_data.length = '0;
        if (num_ok) begin
            if (ovf_next) begin
                res_data.kind = ltc_pkg::KIND_OVERFLOW;
            end else begin
                res_data.kind  = ltc_pkg::KIND_NUMBER;
                res_data.value = accum_next;
            end
        end else if (char_ok) begin
            res_data.kind = ltc_pkg::KIND_NUMBER;
            if (h1 == ltc_pkg::CH_BSLASH) res_data.value = {56'd0, head_esc[7:0]};
            else                          res_data.value = {{56{h1[7]}}, h1};
        end else if (flags_next[ltc_pkg::FLAG_BUF]) begin
            res_data.kind   = ltc_pkg::KIND_BUFFER;
            res_data.length = ltc_pkg::LENGTH_W'(cnt_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accum_reg <= '0;
            ovf_reg   <= 1'b0;
            pos_reg   <= '0;
            head_reg  <= '{default: '0};
            flags_reg <= '1;
            esc_reg   <= 1'b0;
            cnt_reg   <= '0;
        end else if (accept) begin
            if (s_last) begin
                // token done: return to the idle values
                accum_reg <= '0;
                ovf_reg   <= 1'b0;
                pos_reg   <= '0;
                head_reg  <= '{default: '0};
                flags_reg <= '1;
                esc_reg   <= 1'b0;
                cnt_reg   <= '0;
            end else begin
                accum_reg <= accum_next;
                ovf_reg   <= ovf_next;
                pos_reg   <= (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 3'd1;
                if (pos_reg < POS_HEAD) head_reg[pos_reg[1:0]] <= s_ch;
                flags_reg <= flags_next;
                esc_reg   <= esc_next;
                cnt_reg   <= cnt_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/ltc_skid.sv
// Output register with a skid stage for result beats.
`default_nettype none

module ltc_skid (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire ltc_pkg::result_t   in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output ltc_pkg::result_t        out_data
);

    logic             out_valid_reg;
    ltc_pkg::result_t out_data_reg;
    logic             skid_valid_reg;
    ltc_pkg::result_t skid_data_reg;

    assign in_ready  = ~skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_ready) begin
            // advance: skid first, else the incoming beat
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_valid;
            end
        end else if (in_valid && !skid_valid_reg) begin
            // hold: park the beat in the skid stage
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) out_data_reg <= skid_data_reg;
            else if (in_valid)  out_data_reg <= in_data;
        end else if (in_valid && !skid_valid_reg) begin
            skid_data_reg <= in_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/literal_token_classifier_top.sv
// Top level of the literal token classifier.
//
// Input channel (s_valid/s_ready): one token character per beat on s_ch,
// with s_last high on the final character of the token. Tokens follow one
// another with no gap.
// Output channel (m_valid/m_ready): one result beat per token, carrying the
// class in m_kind (number, buffer, plain string, overflow), the parsed value
// in m_value and the unescaped buffer length in m_length.
// Result path: the result of the final character beat is registered into the
// output register, or into the skid stage while the output register still waits.
// Throughput: one character per cycle while s_ready is high; the per-character
// multiply-add for bases 2, 10 and 16 and the class flags are combinational.
// Reset (aresetn low at a clock edge) clears the token state and empties the
// output stages; the next beat starts a new token.
// Stall: the output register plus a one-entry skid stage let a further token
// complete while a result waits; s_ready drops only when both are occupied,
// and it returns once m_ready takes the waiting result.
`default_nettype none

module literal_token_classifier_top #(
    parameter int LEN_BITS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [7:0]   s_ch,
    input  wire logic         s_last,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [1:0]        m_kind,
    output logic [63:0]       m_value,
    output logic [15:0]       m_length
);

    logic             res_valid;
    logic             res_ready;
    ltc_pkg::result_t res_data;
    ltc_pkg::result_t out_data;

    // Character decode and per-token state
    ltc_core #(
        .LEN_BITS (LEN_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_ch      (s_ch),
        .s_last    (s_last),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    // Result register and skid stage
    ltc_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_data   (res_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_kind   = out_data.kind;
    assign m_value  = out_data.value;
    assign m_length = out_data.length;

endmodule

`default_nettype wire
